// ===== hw/rtl/irf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package irf_pkg;

  localparam int unsigned FrameLen = 14;
  localparam int unsigned IdxW     = $clog2(FrameLen);
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned QCntW    = $clog2(QDepth + 1);

  localparam logic [7:0]  SYNC_BYTE   = 8'hA5;
  localparam logic [7:0]  CMD_BYTE    = 8'h06;
  localparam logic [7:0]  LEN_BYTE    = 8'd10;
  localparam logic [7:0]  CRC_POLY    = 8'h07;
  localparam logic [7:0]  FLAGS_BASE  = 8'h11;
  localparam logic [7:0]  FLAG_BATT   = 8'h04;
  localparam logic [7:0]  FLAG_SECOND = 8'h08;
  localparam logic [15:0] BATT_MIN_MV = 16'd3000;
  // 3000 mv floor less half a step of rounding
  localparam logic [15:0] BATT_OFFSET = 16'd2995;
  localparam logic [15:0] BATT_CAP_AT = 16'd1270;
  localparam logic [7:0]  BATT_CODE_MAX = 8'h7F;
  localparam logic [7:0]  BATT_CODE_LOW = 8'h01;
  // floor(d / 10) == (d * 1639) >> 14 for d below 2730
  localparam logic [21:0] BATT_RECIP = 22'd1639;
  localparam int unsigned BattShift  = 14;
  localparam logic [15:0] AGE_MAX = 16'hFFFF;
  localparam logic [15:0] AGE_MIN = 16'h0001;

  // byte positions within the frame
  localparam logic [IdxW-1:0] POS_SYNC   = IdxW'(0);
  localparam logic [IdxW-1:0] POS_CMD    = IdxW'(1);
  localparam logic [IdxW-1:0] POS_LEN    = IdxW'(2);
  localparam logic [IdxW-1:0] POS_SEQ    = IdxW'(3);
  localparam logic [IdxW-1:0] POS_FLAGS  = IdxW'(4);
  localparam logic [IdxW-1:0] POS_MASK0  = IdxW'(5);
  localparam logic [IdxW-1:0] POS_MASK1  = IdxW'(6);
  localparam logic [IdxW-1:0] POS_MASK2  = IdxW'(7);
  localparam logic [IdxW-1:0] POS_MASK3  = IdxW'(8);
  localparam logic [IdxW-1:0] POS_AGE0   = IdxW'(9);
  localparam logic [IdxW-1:0] POS_AGE1   = IdxW'(10);
  localparam logic [IdxW-1:0] POS_BATT   = IdxW'(11);
  localparam logic [IdxW-1:0] POS_CRC    = IdxW'(12);
  localparam logic [IdxW-1:0] POS_SUM    = IdxW'(13);

  typedef struct packed {
    logic [7:0]  seq_low;
    logic [17:0] key_mask;
    logic        ready_known;
    logic [31:0] elapsed_us;
    logic        voltage_valid;
    logic [15:0] battery_mv;
    logic        second_battery;
  } irf_in_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } irf_out_t;

  // one classified report waiting to be serialized
  typedef struct packed {
    logic [7:0]  seq_low;
    logic [7:0]  flags;
    logic [17:0] key_mask;
    logic [15:0] age;
    logic [7:0]  batt_code;
  } irf_desc_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/input_report_framer_unit.sv =====
// start: the sync byte of a report is offered from the output register once the report
//   has been written into the queue, when the output side is free
// frames: 14 bytes per report, one frame byte per cycle from the serializer while a report
//   is queued and out_stall is low; a two-entry report queue lets the input side keep taking reports meanwhile
// reset: synchronous, active low; clears the previous-mask record, the queue and the
//   output valid flag and byte index, no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module input_report_framer_unit (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  irf_pkg::irf_in_t     in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output irf_pkg::irf_out_t    out_item
);
  import irf_pkg::*;

  logic      q_push, q_full, q_pop, q_empty;
  irf_desc_t q_desc, q_head;

  irf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_desc   (q_desc)
  );

  irf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  irf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // a frame boundary is always followed by a sync byte
  a_sync_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_item.last_byte |=>
      !out_valid || out_item.frame_byte == SYNC_BYTE)
    else $error("frame did not restart at sync byte");

  // output only goes idle between frames
  a_start_on_sync: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_item.frame_byte == SYNC_BYTE && !out_item.last_byte)
    else $error("output started mid-frame");

  // the serializer never drains a report the queue does not hold
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty && out_item.last_byte == $past(out_item.last_byte) ||
      !q_empty)
    else $error("pop from empty report queue");

endmodule
`default_nettype wire

// ===== hw/rtl/irf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module irf_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  irf_pkg::irf_in_t     in_item,
  input  wire                  q_full,
  output logic                 q_push,
  output irf_pkg::irf_desc_t   q_desc
);
  import irf_pkg::*;

  logic        have_prev_r, have_prev_nxt;
  logic [17:0] prev_mask_r, prev_mask_nxt;
  logic        changed;
  logic        batt_present;
  logic [15:0] mv_off;
  logic [21:0] batt_prod;
  logic [7:0]  batt_code;
  logic [15:0] age;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  assign changed      = !have_prev_r || (in_item.key_mask != prev_mask_r);
  assign batt_present = in_item.voltage_valid && (in_item.battery_mv != 16'd0);
  assign mv_off       = in_item.battery_mv - BATT_OFFSET;
  assign batt_prod    = 22'(mv_off[10:0]) * BATT_RECIP;

  always_comb begin
    if (in_item.battery_mv < BATT_MIN_MV) begin
      batt_code = BATT_CODE_LOW;
    end else if (mv_off >= BATT_CAP_AT) begin
      batt_code = BATT_CODE_MAX;
    end else begin
      batt_code = {1'b0, batt_prod[BattShift +: 7] + 7'd1};
    end
  end

  always_comb begin
    age = 16'd0;
    if (changed && in_item.ready_known) begin
      if (in_item.elapsed_us[31:16] != 16'd0) begin
        age = AGE_MAX;
      end else if (in_item.elapsed_us[15:0] == 16'd0) begin
        age = AGE_MIN;
      end else begin
        age = in_item.elapsed_us[15:0];
      end
    end
  end

  always_comb begin
    q_desc.seq_low   = in_item.seq_low;
    q_desc.key_mask  = in_item.key_mask;
    q_desc.age       = age;
    q_desc.batt_code = batt_present ? batt_code : 8'd0;
    q_desc.flags     = FLAGS_BASE
                     | (batt_present ? FLAG_BATT : 8'd0)
                     | ((batt_present && in_item.second_battery) ? FLAG_SECOND : 8'd0);
  end

  always_comb begin
    have_prev_nxt = have_prev_r;
    prev_mask_nxt = prev_mask_r;
    if (q_push && changed) begin
      have_prev_nxt = 1'b1;
      prev_mask_nxt = in_item.key_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_mask_r <= '0;
    end else begin
      have_prev_r <= have_prev_nxt;
      prev_mask_r <= prev_mask_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/irf_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module irf_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  irf_pkg::irf_desc_t   push_desc,
  output logic                 full,
  input  wire                  pop,
  output irf_pkg::irf_desc_t   head,
  output logic                 empty
);
  import irf_pkg::*;

  irf_desc_t              mem_r [QDepth];
  logic [QPtrW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]       count_r, count_nxt;
  logic                   do_push, do_pop;

  assign full    = (count_r == QCntW'(QDepth));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCntW'(do_push) - QCntW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/irf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module irf_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_empty,
  input  irf_pkg::irf_desc_t   q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output irf_pkg::irf_out_t    out_item
);
  import irf_pkg::*;

  logic [IdxW-1:0] idx_r, idx_nxt;
  logic [7:0]      crc_r, crc_nxt;
  logic [7:0]      sum_r, sum_nxt;
  logic            valid_r, valid_nxt;
  irf_out_t        item_r, item_nxt;
  logic            load, emit;
  logic [7:0]      cur_byte;

  assign load  = !valid_r || !out_stall;
  assign emit  = load && !q_empty;
  assign q_pop = emit && (idx_r == POS_SUM);

  always_comb begin
    unique case (idx_r)
      POS_SYNC:  cur_byte = SYNC_BYTE;
      POS_CMD:   cur_byte = CMD_BYTE;
      POS_LEN:   cur_byte = LEN_BYTE;
      POS_SEQ:   cur_byte = q_head.seq_low;
      POS_FLAGS: cur_byte = q_head.flags;
      POS_MASK0: cur_byte = q_head.key_mask[7:0];
      POS_MASK1: cur_byte = q_head.key_mask[15:8];
      POS_MASK2: cur_byte = {6'd0, q_head.key_mask[17:16]};
      POS_MASK3: cur_byte = 8'd0;
      POS_AGE0:  cur_byte = q_head.age[7:0];
      POS_AGE1:  cur_byte = q_head.age[15:8];
      POS_BATT:  cur_byte = q_head.batt_code;
      POS_CRC:   cur_byte = crc_r;
      POS_SUM:   cur_byte = sum_r;
      default:   cur_byte = 8'd0;
    endcase
  end

  always_comb begin
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    sum_nxt   = sum_r;
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (load) begin
      valid_nxt = !q_empty;
    end
    if (emit) begin
      item_nxt.frame_byte = cur_byte;
      item_nxt.last_byte  = (idx_r == POS_SUM);
      idx_nxt = (idx_r == POS_SUM) ? POS_SYNC : idx_r + 1'b1;
      // running checksum over bytes 0..12, crc over payload bytes 0..8
      sum_nxt = ((idx_r == POS_SYNC) ? 8'd0 : sum_r) + cur_byte;
      if (idx_r == POS_SYNC) begin
        crc_nxt = 8'd0;
      end else if (idx_r >= POS_SEQ && idx_r <= POS_BATT) begin
        crc_nxt = crc8_step(crc_r, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= POS_SYNC;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r  <= crc_nxt;
    sum_r  <= sum_nxt;
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule
`default_nettype wire
